@@ rtl/msc_pkg.sv @@
// Motor speed command sequencer: shared types, register codes and frame tables.
// Used by every module of the block; depends on nothing.
package msc_pkg;

  // Register indexes on the configuration port
  localparam logic [2:0] CFG_MAX_SPEED       = 3'd0;
  localparam logic [2:0] CFG_FLOOR_SPEED     = 3'd1;
  localparam logic [2:0] CFG_HYSTERESIS      = 3'd2;
  localparam logic [2:0] CFG_POLL_PERIOD     = 3'd3;
  localparam logic [2:0] CFG_STOP_WAIT       = 3'd4;
  localparam logic [2:0] CFG_FAULT_STOP_WAIT = 3'd5;

  // Full-scale demand, hundredths of a percent
  localparam logic [13:0] FULL_SCALE = 14'd10000;

  // x / 625 for x < 2^26 is (x * RECIP_625) >> RECIP_SHIFT, exact over that range
  localparam logic [26:0] RECIP_625   = 27'd109951163;
  localparam int          RECIP_SHIFT = 36;

  // Frame bytes
  localparam logic [7:0] BYTE_SYNC      = 8'h55;
  localparam logic [7:0] BYTE_TAIL      = 8'hCC;
  localparam logic [7:0] BYTE_SPEED_CMD = 8'h02;
  localparam logic [7:0] BYTE_SPEED_REG = 8'h21;
  localparam logic [7:0] BYTE_START     = 8'h00;
  localparam logic [7:0] BYTE_STOP      = 8'h01;
  localparam logic [7:0] BYTE_ACK       = 8'h03;
  localparam logic [7:0] BYTE_ZERO      = 8'h00;

  typedef enum logic [2:0] {
    FR_NONE,
    FR_START,
    FR_STOP,
    FR_STOP2,
    FR_ACK,
    FR_SPEED
  } frame_kind_t;

  typedef struct packed {
    logic [15:0] max_speed;
    logic [15:0] floor_speed;
    logic [15:0] hysteresis;
    logic [15:0] poll_period;
    logic [15:0] stop_wait;
    logic [15:0] fault_stop_wait;
  } cfg_t;

  // One pass worth of output: which frames to send plus the status after the pass
  typedef struct packed {
    frame_kind_t kind;
    logic [15:0] word;
    logic [2:0]  next_stage;
    logic        pin;
    logic        led;
    logic [15:0] ref_speed;
  } job_t;

  typedef struct packed {
    logic        has_byte;
    logic [7:0]  tx_byte;
    logic        last;
    logic [2:0]  next_stage;
    logic        slowdown_pin;
    logic        led_clear;
    logic [15:0] reference_speed;
  } result_t;

  // Number of results a job produces; a silent pass still gives one
  function automatic logic [3:0] frame_len(frame_kind_t kind);
    logic [3:0] len;
    case (kind)
      FR_START: len = 4'd7;
      FR_STOP:  len = 4'd7;
      FR_ACK:   len = 4'd7;
      FR_STOP2: len = 4'd14;
      FR_SPEED: len = 4'd9;
      default:  len = 4'd1;
    endcase
    return len;
  endfunction

  // Byte at position idx of the frame sequence for a job
  function automatic logic [7:0] frame_byte(frame_kind_t kind, logic [3:0] idx,
                                            logic [15:0] word);
    logic [3:0] pos;
    logic [7:0] mid;
    logic [7:0] b;
    pos = ((kind == FR_STOP2) && (idx >= 4'd7)) ? idx - 4'd7 : idx;
    case (kind)
      FR_START: mid = BYTE_START;
      FR_ACK:   mid = BYTE_ACK;
      default:  mid = BYTE_STOP;
    endcase
    b = BYTE_ZERO;
    if (kind == FR_SPEED) begin
      case (pos)
        4'd0:    b = BYTE_SYNC;
        4'd1:    b = BYTE_SPEED_CMD;
        4'd2:    b = BYTE_SPEED_REG;
        4'd5:    b = word[15:8];
        4'd6:    b = word[7:0];
        4'd7:    b = BYTE_TAIL;
        4'd8:    b = BYTE_TAIL;
        default: b = BYTE_ZERO;
      endcase
    end else if (kind != FR_NONE) begin
      case (pos)
        4'd0:    b = BYTE_SYNC;
        4'd2:    b = mid;
        4'd5:    b = BYTE_TAIL;
        4'd6:    b = BYTE_TAIL;
        default: b = BYTE_ZERO;
      endcase
    end
    return b;
  endfunction

endpackage

@@ rtl/msc_if.sv @@
// Motor speed command sequencer: valid/ready channel interfaces for items and results.
// Stand-alone; no package needed.
interface msc_in_if;
  logic               valid;
  logic               ready;
  logic [31:0]        tick_now;
  logic [13:0]        demand_hundredths;
  logic [15:0]        link_fault_status;
  logic signed [15:0] measured_speed;

  modport source (output valid, output tick_now, output demand_hundredths,
                  output link_fault_status, output measured_speed, input ready);
  modport sink   (input valid, input tick_now, input demand_hundredths,
                  input link_fault_status, input measured_speed, output ready);
endinterface

interface msc_out_if;
  logic        valid;
  logic        ready;
  logic        has_byte;
  logic [7:0]  tx_byte;
  logic        last;
  logic [2:0]  next_stage;
  logic        slowdown_pin;
  logic        led_clear;
  logic [15:0] reference_speed;

  modport source (output valid, output has_byte, output tx_byte, output last,
                  output next_stage, output slowdown_pin, output led_clear,
                  output reference_speed, input ready);
  modport sink   (input valid, input has_byte, input tx_byte, input last,
                  input next_stage, input slowdown_pin, input led_clear,
                  input reference_speed, output ready);
endinterface

@@ rtl/msc_ref_calc.sv @@
// Motor speed command sequencer: two-stage pipeline turning demand into reference rpm.
// Depends on msc_pkg (FULL_SCALE, RECIP_625).
module msc_ref_calc #(
  parameter int TICK_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [15:0]           max_speed,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [31:0]           tick_now,
  input  logic [13:0]           demand_hundredths,
  input  logic [15:0]           link_fault_status,
  input  logic signed [15:0]    measured_speed,
  output logic                  item_valid,
  input  logic                  item_ready,
  output logic [TICK_WIDTH-1:0] item_tick,
  output logic [15:0]           item_status,
  output logic signed [15:0]    item_speed,
  output logic [15:0]           item_ref
);
  import msc_pkg::*;

  logic                  s1_valid_r, s2_valid_r;
  logic                  en1, en2;
  logic [63:0]           tick_wide;
  logic [13:0]           demand_sat;
  logic [29:0]           prod;
  logic [52:0]           quot_full;
  logic [TICK_WIDTH-1:0] s1_tick_r, s2_tick_r;
  logic [15:0]           s1_status_r, s2_status_r;
  logic signed [15:0]    s1_speed_r, s2_speed_r;
  logic [29:0]           s1_prod_r;
  logic [15:0]           s2_ref_r;

  // Stage enables: advance into an empty slot or one that moves on
  assign en2      = !s2_valid_r || item_ready;
  assign en1      = !s1_valid_r || en2;
  assign in_ready = en1;

  // Clamp demand and scale by max speed
  always_comb begin
    tick_wide  = {32'd0, tick_now};
    demand_sat = (demand_hundredths > FULL_SCALE) ? FULL_SCALE : demand_hundredths;
    prod       = 30'(demand_sat) * 30'(max_speed);
  end

  // Divide by 10000: drop the low four bits (divide by 16), then multiply by the reciprocal of 625
  assign quot_full = 53'(s1_prod_r[29:4]) * 53'(RECIP_625);

  // Hold stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (en1) s1_valid_r <= in_valid;
      if (en2) s2_valid_r <= s1_valid_r;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en1) begin
      s1_tick_r   <= tick_wide[TICK_WIDTH-1:0];
      s1_status_r <= link_fault_status;
      s1_speed_r  <= measured_speed;
      s1_prod_r   <= prod;
    end
    if (en2) begin
      s2_tick_r   <= s1_tick_r;
      s2_status_r <= s1_status_r;
      s2_speed_r  <= s1_speed_r;
      s2_ref_r    <= quot_full[RECIP_SHIFT+15:RECIP_SHIFT];
    end
  end

  assign item_valid  = s2_valid_r;
  assign item_tick   = s2_tick_r;
  assign item_status = s2_status_r;
  assign item_speed  = s2_speed_r;
  assign item_ref    = s2_ref_r;

endmodule

@@ rtl/msc_stage_ctrl.sv @@
// Motor speed command sequencer: eight-stage sequencer, one stage step per item.
// Depends on msc_pkg (cfg_t, job_t, frame_kind_t).
module msc_stage_ctrl #(
  parameter int TICK_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  msc_pkg::cfg_t         cfg,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  logic [TICK_WIDTH-1:0] item_tick,
  input  logic [15:0]           item_status,
  input  logic signed [15:0]    item_speed,
  input  logic [15:0]           item_ref,
  output logic                  job_valid,
  input  logic                  job_ready,
  output msc_pkg::job_t         job
);
  import msc_pkg::*;

  typedef enum logic [2:0] {
    ST_INIT  = 3'd0,
    ST_POLL  = 3'd1,
    ST_START = 3'd2,
    ST_SLOW  = 3'd3,
    ST_STOP  = 3'd4,
    ST_IDLE  = 3'd5,
    ST_REARM = 3'd6,
    ST_SPEED = 3'd7
  } stage_t;

  localparam logic [17:0] STOP_MARGIN = 18'd10;

  stage_t                stage_r, stage_nxt;
  logic                  running_r, running_nxt;
  logic [15:0]           ref_r, ref_nxt;
  logic [15:0]           fault_r, fault_nxt;
  logic [TICK_WIDTH-1:0] poll_dl_r, poll_dl_nxt;
  logic [TICK_WIDTH-1:0] resume_dl_r, resume_dl_nxt;
  logic                  pin_r, pin_nxt;
  logic                  led;
  frame_kind_t           kind;
  logic [15:0]           word;
  logic                  take;
  logic [16:0]           slow_lim;
  logic signed [17:0]    speed_ext;
  logic signed [17:0]    stop_lim;

  assign item_ready = job_ready;
  assign job_valid  = item_valid;
  assign take       = item_valid && job_ready;

  // Step the stage for the item on hand
  always_comb begin
    stage_nxt     = stage_r;
    running_nxt   = running_r;
    ref_nxt       = ref_r;
    fault_nxt     = fault_r;
    poll_dl_nxt   = poll_dl_r;
    resume_dl_nxt = resume_dl_r;
    pin_nxt       = pin_r;
    led           = 1'b0;
    kind          = FR_NONE;
    word          = ref_r;
    slow_lim      = {1'b0, cfg.floor_speed} + {1'b0, cfg.hysteresis};
    speed_ext     = {{2{item_speed[15]}}, item_speed};
    stop_lim      = $signed({2'b00, cfg.floor_speed} + STOP_MARGIN);
    case (stage_r)
      ST_INIT: begin
        poll_dl_nxt = item_tick + TICK_WIDTH'(cfg.poll_period);
        stage_nxt   = ST_START;
      end
      ST_POLL: begin
        if (item_tick >= poll_dl_r) begin
          fault_nxt = item_status;
          ref_nxt   = item_ref;
          if (item_ref >= cfg.floor_speed) begin
            stage_nxt = ST_START;
          end else if ({1'b0, item_ref} < slow_lim) begin
            stage_nxt = ST_SLOW;
          end else begin
            stage_nxt = ST_SPEED;
          end
        end
      end
      ST_START: begin
        kind        = FR_START;
        running_nxt = 1'b1;
        stage_nxt   = ST_POLL;
      end
      ST_SLOW: begin
        pin_nxt = 1'b1;
        if (running_r) begin
          kind = FR_SPEED;
          word = cfg.floor_speed;
        end
        stage_nxt = ST_STOP;
      end
      ST_STOP: begin
        if (!running_r || (fault_r != 16'd0)) begin
          pin_nxt       = 1'b1;
          kind          = FR_STOP2;
          resume_dl_nxt = item_tick + TICK_WIDTH'(cfg.fault_stop_wait);
          stage_nxt     = ST_IDLE;
        end else if (speed_ext <= stop_lim) begin
          kind          = FR_STOP;
          resume_dl_nxt = item_tick + TICK_WIDTH'(cfg.stop_wait);
          stage_nxt     = ST_IDLE;
        end else if (ref_r >= cfg.floor_speed) begin
          pin_nxt   = 1'b0;
          stage_nxt = ST_SPEED;
        end
      end
      ST_IDLE: begin
        if (item_tick >= resume_dl_r) begin
          kind          = FR_ACK;
          resume_dl_nxt = '0;
          running_nxt   = 1'b0;
          stage_nxt     = ST_REARM;
        end
      end
      ST_REARM: begin
        if (ref_r < cfg.floor_speed) begin
          led       = 1'b1;
          stage_nxt = ST_POLL;
        end
      end
      ST_SPEED: begin
        if (running_r) kind = FR_SPEED;
        poll_dl_nxt = item_tick + TICK_WIDTH'(cfg.poll_period);
        stage_nxt   = ST_POLL;
      end
      default: stage_nxt = ST_INIT;
    endcase
  end

  // Hand the frames and the resulting status to the emitter
  always_comb begin
    job.kind       = kind;
    job.word       = word;
    job.next_stage = stage_nxt;
    job.pin        = pin_nxt;
    job.led        = led;
    job.ref_speed  = ref_nxt;
  end

  // Hold sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r     <= ST_INIT;
      running_r   <= 1'b0;
      ref_r       <= 16'd0;
      fault_r     <= 16'd0;
      poll_dl_r   <= '0;
      resume_dl_r <= '0;
      pin_r       <= 1'b0;
    end else if (take) begin
      stage_r     <= stage_nxt;
      running_r   <= running_nxt;
      ref_r       <= ref_nxt;
      fault_r     <= fault_nxt;
      poll_dl_r   <= poll_dl_nxt;
      resume_dl_r <= resume_dl_nxt;
      pin_r       <= pin_nxt;
    end
  end

endmodule

@@ rtl/msc_frame_tx.sv @@
// Motor speed command sequencer: frame emitter, one result per cycle unless stalled.
// Depends on msc_pkg (job_t, result_t, frame_len, frame_byte).
module msc_frame_tx (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             job_valid,
  output logic             job_ready,
  input  msc_pkg::job_t    job_in,
  output logic             out_valid,
  input  logic             out_ready,
  output msc_pkg::result_t out_res
);
  import msc_pkg::*;

  logic        out_valid_r;
  logic        pend_r;
  job_t        job_r;
  logic [3:0]  idx_r;
  result_t     res_r;
  logic        adv;
  logic        load;
  job_t        cur_job;
  logic [3:0]  cur_idx;
  logic [3:0]  cur_len;
  logic        cur_last;

  // Pick the next byte: rest of the current job, else first of a new one
  always_comb begin
    adv       = !out_valid_r || out_ready;
    job_ready = adv && !pend_r;
    load      = adv && (pend_r || job_valid);
    cur_job   = pend_r ? job_r : job_in;
    cur_idx   = pend_r ? idx_r : 4'd0;
    cur_len   = frame_len(cur_job.kind);
    cur_last  = (cur_idx == (cur_len - 4'd1));
  end

  // Hold control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else if (adv) begin
      out_valid_r <= pend_r || job_valid;
      if (load) pend_r <= !cur_last;
    end
  end

  // Load the output register and advance through the frame
  always_ff @(posedge clk) begin
    if (load) begin
      res_r.has_byte        <= (cur_job.kind != FR_NONE);
      res_r.tx_byte         <= frame_byte(cur_job.kind, cur_idx, cur_job.word);
      res_r.last            <= cur_last;
      res_r.next_stage      <= cur_job.next_stage;
      res_r.slowdown_pin    <= cur_job.pin;
      res_r.led_clear       <= cur_job.led;
      res_r.reference_speed <= cur_job.ref_speed;
      job_r                 <= cur_job;
      idx_r                 <= cur_idx + 4'd1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

`ifndef SYNTHESIS
  // Bytes still pending imply a result on show
  a_pend_shown: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> out_valid_r)
    else $error("frame bytes pending with output register empty");

  // Position never runs past the frame
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (idx_r < frame_len(job_r.kind)))
    else $error("frame position past end of frame");

  // A silent result is always the only one of its pass
  a_silent_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_r.has_byte) |-> res_r.last)
    else $error("silent result not marked last");
`endif

endmodule

@@ rtl/motor_speed_command_sequencer.sv @@
// Motor speed command sequencer: top level with configuration registers.
// Depends on msc_pkg, msc_if, msc_ref_calc, msc_stage_ctrl and msc_frame_tx.
//
// Usage: each item on in_if is one scheduler pass (tick, demand, link status,
// measured speed). The block steps its stage machine once per item and sends
// the resulting frame bytes on out_if, one result item per byte, with last set
// on the final one; a pass that sends nothing gives a single result with
// has_byte low. Registers are written through cfg_we/cfg_index/cfg_data; the
// user must do so only while no item is in flight, which the block does not
// enforce; unknown indexes are ignored. An accepted item passes through the two
// arithmetic stages for the demand scaling, then the output register, before
// its first result is valid. Throughput: one item per cycle while passes send
// nothing and the receiver does not stall; a pass of n bytes (7, 9 or 14)
// holds the emitter for all n results, one byte each, taking no new item.
// Reset (rst_n low, synchronous) returns the stage machine to init, clears
// the running flag, reference speed, latched fault, deadlines and pin, and
// loads the register defaults. When the receiver stalls, the result is held
// and items queue in the two pipeline stages before in_if.ready drops.
module motor_speed_command_sequencer #(
  parameter int TICK_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  msc_in_if.sink      in_if,
  msc_out_if.source   out_if,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import msc_pkg::*;

  cfg_t                  cfg_r;
  logic                  item_valid, item_ready;
  logic [TICK_WIDTH-1:0] item_tick;
  logic [15:0]           item_status;
  logic signed [15:0]    item_speed;
  logic [15:0]           item_ref;
  logic                  job_valid, job_ready;
  job_t                  job;
  result_t               res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_speed       <= 16'd1500;
      cfg_r.floor_speed     <= 16'd300;
      cfg_r.hysteresis      <= 16'd20;
      cfg_r.poll_period     <= 16'd100;
      cfg_r.stop_wait       <= 16'd450;
      cfg_r.fault_stop_wait <= 16'd900;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_SPEED:       cfg_r.max_speed       <= cfg_data;
        CFG_FLOOR_SPEED:     cfg_r.floor_speed     <= cfg_data;
        CFG_HYSTERESIS:      cfg_r.hysteresis      <= cfg_data;
        CFG_POLL_PERIOD:     cfg_r.poll_period     <= cfg_data;
        CFG_STOP_WAIT:       cfg_r.stop_wait       <= cfg_data;
        CFG_FAULT_STOP_WAIT: cfg_r.fault_stop_wait <= cfg_data;
        default: ;
      endcase
    end
  end

  msc_ref_calc #(
    .TICK_WIDTH(TICK_WIDTH)
  ) u_calc (
    .clk               (clk),
    .rst_n             (rst_n),
    .max_speed         (cfg_r.max_speed),
    .in_valid          (in_if.valid),
    .in_ready          (in_if.ready),
    .tick_now          (in_if.tick_now),
    .demand_hundredths (in_if.demand_hundredths),
    .link_fault_status (in_if.link_fault_status),
    .measured_speed    (in_if.measured_speed),
    .item_valid        (item_valid),
    .item_ready        (item_ready),
    .item_tick         (item_tick),
    .item_status       (item_status),
    .item_speed        (item_speed),
    .item_ref          (item_ref)
  );

  msc_stage_ctrl #(
    .TICK_WIDTH(TICK_WIDTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item_tick   (item_tick),
    .item_status (item_status),
    .item_speed  (item_speed),
    .item_ref    (item_ref),
    .job_valid   (job_valid),
    .job_ready   (job_ready),
    .job         (job)
  );

  msc_frame_tx u_tx (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job_in    (job),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_res   (res)
  );

  // Drive the result channel fields
  assign out_if.has_byte        = res.has_byte;
  assign out_if.tx_byte         = res.tx_byte;
  assign out_if.last            = res.last;
  assign out_if.next_stage      = res.next_stage;
  assign out_if.slowdown_pin    = res.slowdown_pin;
  assign out_if.led_clear       = res.led_clear;
  assign out_if.reference_speed = res.reference_speed;

endmodule
